/* hw/rtl/mexp_pkg.sv */
// ----------------------------------------------------------------------------
// mexp_pkg
// shared constants, command and status types of the modular exponentiation core
// ----------------------------------------------------------------------------
package mexp_pkg;

	localparam int RES_W = 30;
	localparam int BASE_W = 32;
	localparam int EXP_W = 63;

	localparam logic [RES_W-1:0] MODULUS = 30'd1000000007;
	// barrett factor floor(2^60 / modulus)
	localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'd1000000007);

	typedef enum logic {
		TAG_SQ  = 1'b0,
		TAG_ACC = 1'b1
	} mexp_tag_t;

	typedef struct packed {
		logic load;
		logic reduce;
		logic issue_sq;
		logic issue_acc;
		logic shift_exp;
		logic emit;
	} mexp_cmd_t;

	typedef struct packed {
		logic base_ge_p;
		logic exp_zero;
		logic exp_bit0;
		logic exp_rest_zero;
		logic pipe_busy;
		logic out_free;
	} mexp_status_t;

endpackage

/* hw/rtl/mexp_modmul.sv */
// ----------------------------------------------------------------------------
// mexp_modmul
// four-stage barrett modular multiplier, product reduced modulo the prime
// ----------------------------------------------------------------------------
module mexp_modmul import mexp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             op_valid,
	input  mexp_tag_t        op_tag,
	input  logic [RES_W-1:0] op_a,
	input  logic [RES_W-1:0] op_b,
	output logic             res_valid,
	output mexp_tag_t        res_tag,
	output logic [RES_W-1:0] res,
	output logic             busy
);

	logic [59:0] z_s1;
	logic [61:0] t_s2;
	logic [31:0] zlo_s2;
	logic [31:0] zlo_s3;
	logic [31:0] qp_s3;
	logic [RES_W-1:0] res_s4;
	logic [3:0] v_q;
	mexp_tag_t tag_s1, tag_s2, tag_s3, tag_s4;

	logic [60:0] qp_full;
	logic [31:0] r0, r1, r2;

	assign qp_full = t_s2[61:31] * MODULUS;
	assign r0 = zlo_s3 - qp_s3;
	assign r1 = r0 - {2'b00, MODULUS};
	assign r2 = r0 - {1'b0, MODULUS, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[2:0], op_valid};
		end
	end

	always_ff @(posedge clk) begin
		z_s1   <= op_a * op_b;
		tag_s1 <= op_tag;
		t_s2   <= z_s1[59:29] * BARRETT_MU;
		zlo_s2 <= z_s1[31:0];
		tag_s2 <= tag_s1;
		qp_s3  <= qp_full[31:0];
		zlo_s3 <= zlo_s2;
		tag_s3 <= tag_s2;
		tag_s4 <= tag_s3;
		if (r0 >= {1'b0, MODULUS, 1'b0}) begin
			res_s4 <= r2[RES_W-1:0];
		end else if (r0 >= {2'b00, MODULUS}) begin
			res_s4 <= r1[RES_W-1:0];
		end else begin
			res_s4 <= r0[RES_W-1:0];
		end
	end

	assign res_valid = v_q[3];
	assign res_tag = tag_s4;
	assign res = res_s4;
	assign busy = |v_q;

endmodule

/* hw/rtl/mexp_datapath.sv */
// ----------------------------------------------------------------------------
// mexp_datapath
// base, square, accumulator and exponent registers around the modular multiplier
// ----------------------------------------------------------------------------
module mexp_datapath import mexp_pkg::*; #(
	parameter int EXP_BITS = 63
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mexp_cmd_t         cmd,
	output mexp_status_t      status,
	input  logic [BASE_W-1:0] base,
	input  logic [EXP_W-1:0]  exponent,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [RES_W-1:0]  result
);

	logic [BASE_W-1:0] sq_q;
	logic [RES_W-1:0] acc_q;
	logic [EXP_BITS-1:0] exp_q;
	logic [RES_W-1:0] result_q;
	logic out_valid_q;

	logic mm_valid;
	mexp_tag_t mm_tag;
	mexp_tag_t res_tag;
	logic res_valid;
	logic [RES_W-1:0] mm_res;
	logic mm_busy;

	assign mm_valid = cmd.issue_sq | cmd.issue_acc;
	assign mm_tag = cmd.issue_acc ? TAG_ACC : TAG_SQ;

	mexp_modmul u_modmul (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (mm_valid),
		.op_tag    (mm_tag),
		.op_a      (cmd.issue_acc ? acc_q : sq_q[RES_W-1:0]),
		.op_b      (sq_q[RES_W-1:0]),
		.res_valid (res_valid),
		.res_tag   (res_tag),
		.res       (mm_res),
		.busy      (mm_busy)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sq_q  <= base;
			acc_q <= RES_W'(1);
			exp_q <= exponent[EXP_BITS-1:0];
		end else begin
			if (cmd.reduce) begin
				sq_q <= sq_q - BASE_W'(MODULUS);
			end else if (res_valid && res_tag == TAG_SQ) begin
				sq_q <= BASE_W'(mm_res);
			end
			if (res_valid && res_tag == TAG_ACC) begin
				acc_q <= mm_res;
			end
			if (cmd.shift_exp) begin
				exp_q <= exp_q >> 1;
			end
		end
		if (cmd.emit) begin
			result_q <= acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.base_ge_p = sq_q >= BASE_W'(MODULUS);
	assign status.exp_zero = exp_q == '0;
	assign status.exp_bit0 = exp_q[0];
	assign status.exp_rest_zero = (exp_q >> 1) == '0;
	assign status.pipe_busy = mm_busy;
	assign status.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign result = result_q;

endmodule

/* hw/rtl/mexp_ctrl.sv */
// ----------------------------------------------------------------------------
// mexp_ctrl
// sequencer for base reduction and the square-and-multiply bit loop
// ----------------------------------------------------------------------------
module mexp_ctrl import mexp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  mexp_status_t status,
	output mexp_cmd_t    cmd
);

	typedef enum logic [5:0] {
		ST_IDLE      = 6'b000001,
		ST_REDUCE    = 6'b000010,
		ST_ISSUE_SQ  = 6'b000100,
		ST_ISSUE_ACC = 6'b001000,
		ST_WAIT      = 6'b010000,
		ST_FINISH    = 6'b100000
	} mexp_state_t;

	mexp_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (status.base_ge_p) begin
					cmd.reduce = 1'b1;
				end else if (status.exp_zero) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_ISSUE_SQ;
				end
			end
			ST_ISSUE_SQ: begin
				cmd.issue_sq = 1'b1;
				state_d = status.exp_bit0 ? ST_ISSUE_ACC : ST_WAIT;
			end
			ST_ISSUE_ACC: begin
				cmd.issue_acc = 1'b1;
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (!status.pipe_busy) begin
					cmd.shift_exp = 1'b1;
					state_d = status.exp_rest_zero ? ST_FINISH : ST_ISSUE_SQ;
				end
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall = state_q != ST_IDLE;

endmodule

/* hw/rtl/modular_exponentiation_core.sv */
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// base to the power exponent modulo 1000000007, right-to-left square-and-multiply
//
// input channel: in_valid / in_stall with base and exponent; output channel:
// out_valid / out_stall with result. a transfer happens when valid is high and
// stall is low. one result per input item, in order.
// after a transfer the base is brought below the modulus by up to four
// subtractions, then each exponent bit up to the highest set one is processed
// with a square, plus a multiply into the accumulator where the bit is set, on
// the four-stage barrett multiplier that both products share. a new item is
// taken as soon as the previous one has moved to the output register, even if
// that result is still stalled. a stalled result holds in the output register
// until taken.
// reset clears the controller, the multiplier valid pipeline and the output
// valid; no other state is reset.
// ----------------------------------------------------------------------------
module modular_exponentiation_core import mexp_pkg::*; #(
	parameter int EXP_BITS = 63
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BASE_W-1:0] base,
	input  logic [EXP_W-1:0]  exponent,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [RES_W-1:0]  result
);

	mexp_cmd_t cmd;
	mexp_status_t status;

	mexp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	mexp_datapath #(
		.EXP_BITS (EXP_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.base      (base),
		.exponent  (exponent),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.result    (result)
	);

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> result < MODULUS)
		else $error("result not below modulus");

	a_issue_idle_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue_sq |-> !status.pipe_busy)
		else $error("square issued while multiplier busy");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free)
		else $error("result register overwritten");

	a_load_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> in_stall)
		else $error("input not stalled after transfer");

endmodule
